@@ hdl/pipt_pkg.sv @@
// Package for the point-in-polygon test core: field widths, codes and
// coordinate types shared by the core. Depends on nothing.
package pipt_pkg;

    localparam int LAT_W          = 28;
    localparam int LON_W          = 29;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = 7;
    localparam int MAX_VERTICES_D = 64;

    // Differences and cross products of the edge test
    localparam int DLAT_W = LAT_W + 1;
    localparam int DLON_W = LON_W + 1;
    localparam int PROD_W = DLAT_W + DLON_W;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic signed [LAT_W-1:0]  lat_t;
    typedef logic signed [LON_W-1:0]  lon_t;
    typedef logic signed [DLAT_W-1:0] dlat_t;
    typedef logic signed [DLON_W-1:0] dlon_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

@@ hdl/point_in_polygon_test_core.sv @@
// Point-in-polygon test core: vertex store plus a crossing-number sequencer
// around one shared signed multiplier. Depends on pipt_pkg.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  in        | in_valid / in_ready    | kind, vertex_index, point_lat, point_lon
//  out       | out_valid / out_ready  | is_inside
//  cfg       | cfg_valid / cfg_ready  | cfg_vertex_count
//
// A load is written into the store as it is accepted. A query passes S_V0, then
// per edge S_DIFF and S_MUL1 when the latitude window or longitude bound rejects
// it (or the edge is vertical), or S_DIFF, S_MUL1, S_MUL2 and S_CMP when the exact
// cross-multiplied test is needed; the single multiplier forms both cross products
// in turn. Fewer than two vertices skip to S_DONE. in_ready is low during a query.
// Reset clears the control state and the vertex count; the vertex store is not
// cleared, and its slots must be loaded before a query reads them. A finished
// result waits in the output register while the next request is taken; a second
// result stalls in the final state until the first is taken.
module point_in_polygon_test_core #(
    parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_D
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic [pipt_pkg::IDX_W-1:0] vertex_index,
    input  pipt_pkg::lat_t             point_lat,
    input  pipt_pkg::lon_t             point_lon,
    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       is_inside,
    // configuration channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pipt_pkg::CNT_W-1:0] cfg_vertex_count
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int WW = pipt_pkg::LAT_W + pipt_pkg::LON_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_V0,
        S_DIFF,
        S_MUL1,
        S_MUL2,
        S_CMP,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Vertex store: one write port (loads), one registered read port
    // ------------------------------------------------------------------
    logic [WW-1:0] vert_mem [MAX_VERTICES];
    logic [WW-1:0] rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vert_mem[wr_addr] <= {point_lat, point_lon};
        end
        if (rd_en)
        begin
            rd_data_reg <= vert_mem[rd_addr];
        end
    end

    pipt_pkg::lat_t rd_lat;
    pipt_pkg::lon_t rd_lon;
    assign rd_lat = rd_data_reg[WW-1:pipt_pkg::LON_W];
    assign rd_lon = rd_data_reg[pipt_pkg::LON_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    state_t                   state_reg,   state_next;
    logic [pipt_pkg::CNT_W-1:0] count_reg, count_next;
    logic [CW-1:0]            n_reg,       n_next;
    logic [AW-1:0]            i_reg,       i_next;
    pipt_pkg::lat_t           plat_reg,    plat_next;
    pipt_pkg::lon_t           plon_reg,    plon_next;
    pipt_pkg::lat_t           v0lat_reg,   v0lat_next;
    pipt_pkg::lon_t           v0lon_reg,   v0lon_next;
    pipt_pkg::lat_t           alat_reg,    alat_next;
    pipt_pkg::lon_t           alon_reg,    alon_next;
    pipt_pkg::dlat_t          dlat_reg,    dlat_next;
    pipt_pkg::dlon_t          dlon_reg,    dlon_next;
    pipt_pkg::dlon_t          dpl_reg,     dpl_next;
    pipt_pkg::dlat_t          dpa_reg,     dpa_next;
    logic                     win_reg,     win_next;
    logic                     vert_reg,    vert_next;
    logic                     up_reg,      up_next;
    logic                     last_reg,    last_next;
    pipt_pkg::prod_t          lhs_reg,     lhs_next;
    pipt_pkg::prod_t          rhs_reg,     rhs_next;
    logic                     flag_reg,    flag_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     inside_reg,  inside_next;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                 in_acc;
    logic                 last_now;
    logic [CW:0]          ahead2;
    pipt_pkg::lat_t       blat;
    pipt_pkg::lon_t       blon;
    pipt_pkg::lat_t       lat_lo;
    pipt_pkg::lat_t       lat_hi;
    pipt_pkg::lon_t       lon_max;
    pipt_pkg::dlon_t      mul_a;
    pipt_pkg::dlat_t      mul_b;
    pipt_pkg::prod_t      prod;
    logic                 cross_ok;

    assign in_acc   = in_valid && in_ready;
    assign last_now = ((CW'(i_reg) + CW'(1)) == n_reg);
    assign ahead2   = (CW+1)'(i_reg) + (CW+1)'(2);

    // Edge end: wrap back to vertex zero on the closing edge
    assign blat = last_now ? v0lat_reg : rd_lat;
    assign blon = last_now ? v0lon_reg : rd_lon;

    assign lat_lo  = (alat_reg < blat) ? alat_reg : blat;
    assign lat_hi  = (alat_reg < blat) ? blat : alat_reg;
    assign lon_max = (alon_reg < blon) ? blon : alon_reg;

    // Shared multiplier: (p.lon - a.lon) * dlat, then (b.lon - a.lon) * (p.lat - a.lat)
    assign mul_a = (state_reg == S_MUL1) ? dpl_reg : dlon_reg;
    assign mul_b = (state_reg == S_MUL1) ? dlat_reg : dpa_reg;
    assign prod  = pipt_pkg::PROD_W'(mul_a) * pipt_pkg::PROD_W'(mul_b);

    // Inequality flips for downward edges
    assign cross_ok = up_reg ? (lhs_reg <= rhs_reg) : (lhs_reg >= rhs_reg);

    // ------------------------------------------------------------------
    // Store port control
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_en   = in_acc && (kind == pipt_pkg::KIND_LOAD)
                  && (int'(vertex_index) < MAX_VERTICES);
        wr_addr = AW'(vertex_index);
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            S_IDLE:
            begin
                rd_en   = in_acc && (kind == pipt_pkg::KIND_QUERY);
                rd_addr = '0;
            end
            S_V0:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(1);
            end
            S_DIFF:
            begin
                // prefetch the end vertex of the following edge
                rd_en   = (ahead2 < (CW+1)'(n_reg));
                rd_addr = AW'(ahead2);
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        plat_next      = plat_reg;
        plon_next      = plon_reg;
        v0lat_next     = v0lat_reg;
        v0lon_next     = v0lon_reg;
        alat_next      = alat_reg;
        alon_next      = alon_reg;
        dlat_next      = dlat_reg;
        dlon_next      = dlon_reg;
        dpl_next       = dpl_reg;
        dpa_next       = dpa_reg;
        win_next       = win_reg;
        vert_next      = vert_reg;
        up_next        = up_reg;
        last_next      = last_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        flag_next      = flag_reg;
        inside_next    = inside_reg;
        // drop the result once it is taken
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_vertex_count;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (kind == pipt_pkg::KIND_QUERY))
                begin
                    plat_next = point_lat;
                    plon_next = point_lon;
                    flag_next = 1'b0;
                    i_next    = '0;
                    // clamp the count to the store size
                    if (int'(count_reg) > MAX_VERTICES)
                    begin
                        n_next = CW'(MAX_VERTICES);
                    end
                    else
                    begin
                        n_next = CW'(count_reg);
                    end
                    // no edge can cross with fewer than two vertices
                    if (int'(count_reg) < 2)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_V0;
                    end
                end
            end

            S_V0:
            begin
                // hold vertex zero for the closing edge and as first edge start
                v0lat_next = rd_lat;
                v0lon_next = rd_lon;
                alat_next  = rd_lat;
                alon_next  = rd_lon;
                state_next = S_DIFF;
            end

            S_DIFF:
            begin
                win_next  = (plat_reg > lat_lo) && (plat_reg <= lat_hi)
                            && (plon_reg <= lon_max);
                vert_next = (alon_reg == blon);
                up_next   = (blat > alat_reg);
                last_next = last_now;
                dlat_next = pipt_pkg::DLAT_W'(blat) - pipt_pkg::DLAT_W'(alat_reg);
                dlon_next = pipt_pkg::DLON_W'(blon) - pipt_pkg::DLON_W'(alon_reg);
                dpl_next  = pipt_pkg::DLON_W'(plon_reg) - pipt_pkg::DLON_W'(alon_reg);
                dpa_next  = pipt_pkg::DLAT_W'(plat_reg) - pipt_pkg::DLAT_W'(alat_reg);
                // advance: this edge's end starts the next edge
                alat_next  = blat;
                alon_next  = blon;
                i_next     = i_reg + AW'(1);
                state_next = S_MUL1;
            end

            S_MUL1:
            begin
                lhs_next = prod;
                if (!win_reg || vert_reg)
                begin
                    if (win_reg)
                    begin
                        flag_next = !flag_reg;
                    end
                    state_next = last_reg ? S_DONE : S_DIFF;
                end
                else
                begin
                    state_next = S_MUL2;
                end
            end

            S_MUL2:
            begin
                rhs_next   = prod;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (cross_ok)
                begin
                    flag_next = !flag_reg;
                end
                state_next = last_reg ? S_DONE : S_DIFF;
            end

            S_DONE:
            begin
                // stall until the previous result has been taken
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    inside_next    = flag_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            plat_reg      <= '0;
            plon_reg      <= '0;
            v0lat_reg     <= '0;
            v0lon_reg     <= '0;
            alat_reg      <= '0;
            alon_reg      <= '0;
            dlat_reg      <= '0;
            dlon_reg      <= '0;
            dpl_reg       <= '0;
            dpa_reg       <= '0;
            win_reg       <= 1'b0;
            vert_reg      <= 1'b0;
            up_reg        <= 1'b0;
            last_reg      <= 1'b0;
            lhs_reg       <= '0;
            rhs_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            inside_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            plat_reg      <= plat_next;
            plon_reg      <= plon_next;
            v0lat_reg     <= v0lat_next;
            v0lon_reg     <= v0lon_next;
            alat_reg      <= alat_next;
            alon_reg      <= alon_next;
            dlat_reg      <= dlat_next;
            dlon_reg      <= dlon_next;
            dpl_reg       <= dpl_next;
            dpa_reg       <= dpa_next;
            win_reg       <= win_next;
            vert_reg      <= vert_next;
            up_reg        <= up_next;
            last_reg      <= last_next;
            lhs_reg       <= lhs_next;
            rhs_reg       <= rhs_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            inside_reg    <= inside_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign is_inside = inside_reg;

endmodule

@@ bench/point_in_polygon_test_core_tb.sv @@
// Self-checking bench for point_in_polygon_test_core: loads polygons, fires point queries
// and checks every inside flag against a crossing-number predictor kept in the bench.
// Depends on pipt_pkg and the core RTL only.
module point_in_polygon_test_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [pipt_pkg::IDX_W-1:0] index_t;
    typedef logic [pipt_pkg::CNT_W-1:0] count_t;

    // One request as the driver presents it
    typedef struct {
        logic           kind;
        index_t         slot;
        pipt_pkg::lat_t lat;
        pipt_pkg::lon_t lon;
    } request_t;

    // Full field extremes and the legal coordinate span (degrees times 2^20)
    localparam int LAT_TOP  = 2 ** (pipt_pkg::LAT_W - 1) - 1;
    localparam int LAT_BOT  = -(2 ** (pipt_pkg::LAT_W - 1));
    localparam int LON_TOP  = 2 ** (pipt_pkg::LON_W - 1) - 1;
    localparam int LON_BOT  = -(2 ** (pipt_pkg::LON_W - 1));
    localparam int LAT_SPAN = 94371840;
    localparam int LON_SPAN = 188743680;
    localparam int DEG      = 1 << 20;

    // Cycles with no handshake before the watchdog fires; well above the slowest query.
    localparam int STALL_LIMIT   = 2000;
    // Pause that lets a last load complete before a register write.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 300;
    localparam int TARGET_ITEMS  = 900;
    localparam int STEADY_FROM   = 780;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    logic           kind = pipt_pkg::KIND_LOAD;
    index_t         vertex_index = '0;
    pipt_pkg::lat_t point_lat = '0;
    pipt_pkg::lon_t point_lon = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic           is_inside;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    count_t         cfg_vertex_count = '0;

    // Predicted polygon: vertex store and vertex count as the core should hold them
    pipt_pkg::lat_t poly_lat [pipt_pkg::MAX_VERTICES_D];
    pipt_pkg::lon_t poly_lon [pipt_pkg::MAX_VERTICES_D];
    count_t         poly_count = '0;

    request_t pending_requests[$];
    bit       expected_inside[$];
    request_t next_req;
    bit       want;

    int req_issued   = 0;
    int req_taken    = 0;
    int cfg_issued   = 0;
    int cfg_taken    = 0;
    int mismatches   = 0;
    int stall_cycles = 0;
    int items_pushed = 0;

    // Idle shaping; idle_pct and steady are shared by both sides
    int idle_pct   = 0;
    bit steady     = 1'b0;
    int gap_left   = 0;
    int stall_left = 0;
    bit drain_hold = 1'b0;

    // Coordinate grid of the current polygon; equal coordinates on the grid give
    // vertical and horizontal edges and points level with vertices.
    int base_lat, base_lon, step_lat, step_lon;

    point_in_polygon_test_core #(
        .MAX_VERTICES(pipt_pkg::MAX_VERTICES_D)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .vertex_index     (vertex_index),
        .point_lat        (point_lat),
        .point_lon        (point_lon),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .is_inside        (is_inside),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_vertex_count (cfg_vertex_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Does the ray from p toward growing longitude cross edge a->b?
    // Exact test by cross-multiplication in 64 bits; flip the inequality
    // when the edge runs toward lower latitude.
    function automatic bit edge_flips(pipt_pkg::lat_t alat, pipt_pkg::lon_t alon,
                                      pipt_pkg::lat_t blat, pipt_pkg::lon_t blon,
                                      pipt_pkg::lat_t plat, pipt_pkg::lon_t plon);
        longint lo, hi, lon_max, dlat, lhs, rhs;
        lo      = (alat < blat) ? longint'(alat) : longint'(blat);
        hi      = (alat < blat) ? longint'(blat) : longint'(alat);
        lon_max = (alon < blon) ? longint'(blon) : longint'(alon);
        if (!(longint'(plat) > lo && longint'(plat) <= hi && longint'(plon) <= lon_max))
            return 1'b0;
        if (alon == blon)
            return 1'b1;
        dlat = longint'(blat) - longint'(alat);
        lhs  = (longint'(plon) - longint'(alon)) * dlat;
        rhs  = (longint'(plat) - longint'(alat)) * (longint'(blon) - longint'(alon));
        return (dlat > 0) ? (lhs <= rhs) : (lhs >= rhs);
    endfunction

    // Crossing parity over all edges in use; the last edge closes back to vertex 0.
    // A count above capacity is clamped to capacity.
    function automatic bit ray_parity(pipt_pkg::lat_t plat, pipt_pkg::lon_t plon);
        int n, j;
        bit parity;
        n      = (poly_count > pipt_pkg::MAX_VERTICES_D) ? pipt_pkg::MAX_VERTICES_D
                                                          : int'(poly_count);
        parity = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            if (edge_flips(poly_lat[i], poly_lon[i], poly_lat[j], poly_lon[j], plat, plon))
                parity = !parity;
        end
        return parity;
    endfunction

    // Sample every handshake at the rising edge: update the predicted state on
    // each accepted request, check each accepted result against the oldest
    // prediction, and track cycles without progress for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (kind == pipt_pkg::KIND_LOAD)
                begin
                    poly_lat[vertex_index] = point_lat;
                    poly_lon[vertex_index] = point_lon;
                end
                else
                    expected_inside = {expected_inside, ray_parity(point_lat, point_lon)};
                req_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_inside.size() == 0)
                begin
                    $error("is_inside: result with no query pending, actual %0b", is_inside);
                    mismatches++;
                end
                else
                begin
                    want = expected_inside.pop_front();
                    if (is_inside !== want)
                    begin
                        $error("is_inside mismatch: expected %0b, actual %0b", want, is_inside);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                poly_count = cfg_vertex_count;
                cfg_taken++;
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    // Request driver: hold the payload until the request is taken, then either
    // idle for a random burst, wait for all results (drain), or present the next one.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken == req_issued)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (drain_hold && expected_inside.size() != 0)
                in_valid <= 1'b0;
            else if (pending_requests.size() == 0)
                in_valid <= 1'b0;
            else if (!steady && $urandom_range(0, 99) < idle_pct)
            begin
                gap_left = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end
            else
            begin
                next_req = pending_requests.pop_front();
                kind         <= next_req.kind;
                vertex_index <= next_req.slot;
                point_lat    <= next_req.lat;
                point_lon    <= next_req.lon;
                in_valid     <= 1'b1;
                req_issued++;
                drain_hold = !steady && ($urandom_range(0, 39) == 0);
            end
        end
    end

    // Result side: stall in random bursts, never while the run is steady.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic push_req(logic op, int slot, int lat, int lon);
        request_t r;
        r.kind = op;
        r.slot = index_t'(slot);
        r.lat  = pipt_pkg::lat_t'(lat);
        r.lon  = pipt_pkg::lon_t'(lon);
        pending_requests = {pending_requests, r};
        items_pushed++;
    endtask

    task automatic push_load(int slot, int lat, int lon);
        push_req(pipt_pkg::KIND_LOAD, slot, lat, lon);
    endtask

    task automatic push_query(int lat, int lon);
        push_req(pipt_pkg::KIND_QUERY, 0, lat, lon);
    endtask

    // Wait until nothing is queued, in flight or expected, then let a load settle.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || req_taken != req_issued ||
               expected_inside.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write vertex_count with the core idle; drop valid right after the write.
    task automatic write_count(int value);
        wait_idle();
        cfg_vertex_count <= count_t'(value);
        cfg_valid        <= 1'b1;
        cfg_issued++;
        do
            @(negedge clk);
        while (cfg_taken != cfg_issued);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_step();
        case ($urandom_range(0, 3))
            0:       return 1;
            1:       return int'($urandom_range(2, 64));
            2:       return 1 << $urandom_range(10, 20);
            default: return int'($urandom_range(1, 1 << 22));
        endcase
    endfunction

    // Mostly grid values near the polygon; now and then any legal value or any
    // bit pattern of the field. Points also land on half steps and just outside.
    function automatic int pick_coord(int base, int step, int span, int width, bit is_point);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return int'($urandom) >>> (32 - width);
        if (sel == 1)
            return int'($urandom_range(0, 2 * span)) - span;
        if (is_point)
            return base + (int'($urandom_range(0, 16)) - 2) * step / 2;
        return base + int'($urandom_range(0, 6)) * step;
    endfunction

    // One polygon setting: write the count, load every slot in use, then query,
    // with some reloads inside the polygon and some loads to unused slots.
    task automatic run_phase(int cnt);
        int n, queries, r;
        n = (cnt > pipt_pkg::MAX_VERTICES_D) ? pipt_pkg::MAX_VERTICES_D : cnt;
        write_count(cnt);
        steady   = (items_pushed >= STEADY_FROM);
        idle_pct = steady ? 0 : int'($urandom_range(0, 2)) * 20;
        base_lat = int'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN;
        base_lon = int'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN;
        step_lat = pick_step();
        step_lon = pick_step();
        for (int k = 0; k < n; k++)
            push_load(k, pick_coord(base_lat, step_lat, LAT_SPAN, pipt_pkg::LAT_W, 1'b0),
                      pick_coord(base_lon, step_lon, LON_SPAN, pipt_pkg::LON_W, 1'b0));
        queries = (n <= 8) ? $urandom_range(6, 16) : $urandom_range(3, 6);
        repeat (queries)
        begin
            r = $urandom_range(0, 99);
            if (r < 10 && n > 0)
                push_load($urandom_range(0, n - 1),
                          pick_coord(base_lat, step_lat, LAT_SPAN, pipt_pkg::LAT_W, 1'b0),
                          pick_coord(base_lon, step_lon, LON_SPAN, pipt_pkg::LON_W, 1'b0));
            else if (r < 15 && n < pipt_pkg::MAX_VERTICES_D)
                push_load($urandom_range(n, pipt_pkg::MAX_VERTICES_D - 1),
                          pick_coord(base_lat, step_lat, LAT_SPAN, pipt_pkg::LAT_W, 1'b0),
                          pick_coord(base_lon, step_lon, LON_SPAN, pipt_pkg::LON_W, 1'b0));
            push_query(pick_coord(base_lat, step_lat, LAT_SPAN, pipt_pkg::LAT_W, 1'b1),
                       pick_coord(base_lon, step_lon, LON_SPAN, pipt_pkg::LON_W, 1'b1));
        end
    endtask

    initial
    begin : stimulus
        int r, cnt;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_pct = 20;

        // Empty polygon straight out of reset: never inside, even at the field corners.
        push_query(LAT_TOP, LON_BOT);
        push_query(0, 0);

        // Single vertex: no edge can cross.
        write_count(1);
        push_load(0, LAT_BOT, LON_TOP);
        push_query(LAT_BOT, LON_BOT);

        // Triangle spanning the full fields: slanted edges both ways, widest products.
        write_count(3);
        push_load(0, LAT_BOT, LON_BOT);
        push_load(1, LAT_TOP, 0);
        push_load(2, 0, LON_TOP);
        push_query(0, 0);
        push_query(LAT_TOP, LON_BOT);
        push_query(LAT_BOT, LON_TOP);
        push_query(1, LON_BOT);

        // Unit square: vertical and horizontal edges, points on edges and vertex levels.
        write_count(4);
        push_load(0, 0, 0);
        push_load(1, 0, DEG);
        push_load(2, DEG, DEG);
        push_load(3, DEG, 0);
        push_query(DEG / 2, DEG / 2);
        push_query(DEG, DEG / 2);
        push_query(0, DEG / 2);
        push_query(DEG / 2, DEG);
        push_query(DEG / 2, 0);
        push_query(DEG / 2, 2 * DEG);
        push_query(DEG / 2, -DEG);

        // Count extremes first: above capacity, zero, full capacity.
        run_phase(127);
        run_phase(0);
        run_phase(pipt_pkg::MAX_VERTICES_D);

        // Mostly small polygons, a few large ones.
        while (items_pushed < TARGET_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                cnt = $urandom_range(0, 2);
            else if (r < 86)
                cnt = $urandom_range(3, 8);
            else if (r < 96)
                cnt = $urandom_range(9, 24);
            else if (r < 98)
                cnt = pipt_pkg::MAX_VERTICES_D;
            else
                cnt = $urandom_range(pipt_pkg::MAX_VERTICES_D + 1, 127);
            run_phase(cnt);
        end

        // Drain all results, then watch a while for any stray result.
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
